// File: hdl/lcsr_pkg.sv
// ----------------------------------------------------------------------------
// lcsr_pkg: shared constants and types of the combined LCG shuffle generator
// Holds the generator constants, the Schrage reciprocal constants and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsr_pkg;

    // Word width of every generator state and result.
    localparam int DATA_W = 31;

    // Generator one: modulus, multiplier, Schrage quotient and remainder.
    localparam logic [31:0] M1 = 32'd2147483563;
    localparam logic [15:0] A1 = 16'd40014;
    localparam logic [15:0] Q1 = 16'd53668;
    localparam logic [15:0] R1 = 16'd12211;

    // Generator two.
    localparam logic [31:0] M2 = 32'd2147483399;
    localparam logic [15:0] A2 = 16'd40692;
    localparam logic [15:0] Q2 = 16'd52774;
    localparam logic [15:0] R2 = 16'd3791;

    // Wrap amount for the combined output.
    localparam logic [31:0] WRAP = M1 - 32'd1;

    // Reset value of generator two.
    localparam logic [DATA_W-1:0] SEED2_RESET = 31'd123456789;

    // The quotient x / Q is formed as (x * RECIP) >> SCH_SHIFT plus one correction.
    localparam int          SCH_SHIFT = 47;
    localparam logic [31:0] RECIP1    = 32'((64'd1 << SCH_SHIFT) / 64'(Q1));
    localparam logic [31:0] RECIP2    = 32'((64'd1 << SCH_SHIFT) / 64'(Q2));

    // Cycles one generator step spends in the Schrage unit.
    localparam int         PH_W     = 2;
    localparam logic [1:0] PH_LAST  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a request is taken this cycle
        logic reseed;   // the request taken is a reseed
        logic sel_gen2; // Schrage unit works on generator two
        logic wr_g1;    // load generator one from the Schrage unit
        logic wr_g2;    // load generator two from the Schrage unit
        logic fill_wr;  // write generator one's new state into the table
        logic finish;   // combine, refill the slot and load the result
    } lcsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_hold; // result register is full and not being taken
    } lcsr_sts_t;

endpackage

`default_nettype wire

// File: hdl/lcsr_if.sv
// ----------------------------------------------------------------------------
// lcsr_if: request and result channels of the combined LCG shuffle generator
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcsr_req_if
    import lcsr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [DATA_W-1:0] seed_value;

    modport source (output valid, output command, output seed_value, input ready);
    modport sink   (input valid, input command, input seed_value, output ready);
endinterface

interface lcsr_rsp_if
    import lcsr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// File: hdl/lcsr_schrage.sv
// ----------------------------------------------------------------------------
// lcsr_schrage: pipelined Schrage step for either generator
// Three register stages; the new state is formed combinationally from the
// products held in the third stage. The pipeline runs every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_schrage
    import lcsr_pkg::*;
(
    input  logic              clk,
    input  logic [DATA_W-1:0] x,
    input  logic              gen2,
    output logic [DATA_W-1:0] y
);

    logic [62:0]       prod1_reg;
    logic [DATA_W-1:0] x1_reg;
    logic              sel1_reg;
    logic [15:0]       k2_reg;
    logic [16:0]       r2_reg;
    logic              sel2_reg;
    logic [31:0]       pa3_reg;
    logic [31:0]       pb3_reg;
    logic              sel3_reg;

    logic [15:0] kest;
    logic [15:0] q2;
    logic [31:0] kq;
    logic [31:0] r0;
    logic [15:0] q3;
    logic [15:0] k3;
    logic [15:0] r3;
    logic [31:0] diff;
    logic [31:0] wrapped;

    // Stage 1: multiply by the reciprocal of Q.
    always_ff @(posedge clk)
    begin
        prod1_reg <= {32'd0, x} * {31'd0, (gen2 ? RECIP2 : RECIP1)};
        x1_reg    <= x;
        sel1_reg  <= gen2;
    end

    // Stage 2: estimated quotient and its remainder, which lies below 2*Q.
    always_comb
    begin
        kest = prod1_reg[62:SCH_SHIFT];
        q2   = sel1_reg ? Q2 : Q1;
        kq   = kest * q2;
        r0   = {1'b0, x1_reg} - kq;
    end

    always_ff @(posedge clk)
    begin
        k2_reg   <= kest;
        r2_reg   <= r0[16:0];
        sel2_reg <= sel1_reg;
    end

    // Stage 3: one correction step, then the two Schrage products.
    always_comb
    begin
        q3 = sel2_reg ? Q2 : Q1;
        if (r2_reg >= {1'b0, q3})
        begin
            k3 = k2_reg + 16'd1;
            r3 = 16'(r2_reg - {1'b0, q3});
        end
        else
        begin
            k3 = k2_reg;
            r3 = r2_reg[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pa3_reg  <= (sel2_reg ? A2 : A1) * r3;
        pb3_reg  <= k3 * (sel2_reg ? R2 : R1);
        sel3_reg <= sel2_reg;
    end

    // Output: difference of the products, lifted by the modulus when negative.
    always_comb
    begin
        diff    = pa3_reg - pb3_reg;
        wrapped = diff + (sel3_reg ? M2 : M1);
        y       = diff[31] ? wrapped[DATA_W-1:0] : diff[DATA_W-1:0];
    end

endmodule

`default_nettype wire

// File: hdl/lcsr_datapath.sv
// ----------------------------------------------------------------------------
// lcsr_datapath: generator states, shuffle table and result register
// Holds both generator states, the last output, the start seed register,
// the shuffle table memory with its valid bits, the slot divider and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_datapath
    import lcsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int IW          = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic [DATA_W-1:0] seed_value,
    input  lcsr_cmd_t         cmd,
    input  logic [IW-1:0]     fill_idx,
    output lcsr_sts_t         sts,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [DATA_W-1:0] rsp_data
);

    localparam int QW  = IW + 1;
    localparam int QW1 = QW + 1;
    localparam int PW  = DATA_W + QW;
    localparam logic [DATA_W-1:0] SLOT_DIV   =
        DATA_W'(32'd1 + WRAP / 32'(TABLE_DEPTH));
    localparam logic [QW-1:0]     SLOT_RECIP =
        QW'((64'd1 << DATA_W) / 64'(SLOT_DIV));
    localparam logic [QW1-1:0]    SLOT_MAX   = QW1'(TABLE_DEPTH - 1);

    logic [DATA_W-1:0] start_seed_reg, start_seed_next;
    logic [DATA_W-1:0] g1_reg, g1_next;
    logic [DATA_W-1:0] g2_reg, g2_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic              seeded_reg, seeded_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0] rsp_data_reg, rsp_data_next;
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [QW-1:0]     qest_reg;
    logic [DATA_W-1:0] lastq_reg;
    logic [IW-1:0]     slot_reg, slot_next;
    logic [DATA_W-1:0] rd_word_reg;
    logic              rd_vld_reg;

    logic [DATA_W-1:0] shuf_mem [TABLE_DEPTH];

    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] seed_in;
    logic [DATA_W-1:0] start_red;
    logic [DATA_W-1:0] start_val;
    logic [PW-1:0]     qprod;
    logic [PW-1:0]     qdiv;
    logic [PW-1:0]     qrem;
    logic [QW1-1:0]    qfix;
    logic [DATA_W-1:0] entry;
    logic [31:0]       comb_diff;
    logic [31:0]       comb_wrap;
    logic [DATA_W-1:0] comb_out;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    // Shared Schrage unit; it steps whichever generator the controller picks.
    lcsr_schrage u_schrage (
        .clk  (clk),
        .x    (cmd.sel_gen2 ? g2_reg : g1_reg),
        .gen2 (cmd.sel_gen2),
        .y    (y)
    );

    // Seed conditioning: zero becomes one; the start seed is also reduced.
    always_comb
    begin
        seed_in   = (seed_value == '0) ? DATA_W'(1) : seed_value;
        start_red = (start_seed_reg >= M1[DATA_W-1:0]) ?
                    start_seed_reg - M1[DATA_W-1:0] : start_seed_reg;
        start_val = (start_red == '0) ? DATA_W'(1) : start_red;
    end

    // Slot divider, stage 1: quotient estimate by the reciprocal of the divisor.
    always_comb
    begin
        qprod = {{QW{1'b0}}, last_reg} * {{DATA_W{1'b0}}, SLOT_RECIP};
    end

    // Slot divider, stage 2: one correction step and a clamp to the table.
    always_comb
    begin
        qdiv = {{DATA_W{1'b0}}, qest_reg} * {{QW{1'b0}}, SLOT_DIV};
        qrem = {{QW{1'b0}}, lastq_reg} - qdiv;
        qfix = (qrem >= {{QW{1'b0}}, SLOT_DIV}) ? {1'b0, qest_reg} + QW1'(1)
                                                 : {1'b0, qest_reg};
        slot_next = (qfix > SLOT_MAX) ? SLOT_MAX[IW-1:0] : qfix[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        qest_reg  <= qprod[PW-1:DATA_W];
        lastq_reg <= last_reg;
        slot_reg  <= slot_next;
    end

    // Combine the table word with generator two and wrap into range.
    always_comb
    begin
        entry     = rd_vld_reg ? rd_word_reg : '0;
        comb_diff = {1'b0, entry} - {1'b0, g2_reg};
        comb_wrap = comb_diff + WRAP;
        comb_out  = ($signed(comb_diff) < 32'sd1) ? comb_wrap[DATA_W-1:0]
                                                  : comb_diff[DATA_W-1:0];
    end

    // Table write port: fill during reseed, slot refill at the end of a draw.
    always_comb
    begin
        wr_en   = cmd.fill_wr | cmd.finish;
        wr_addr = cmd.fill_wr ? fill_idx : slot_reg;
        wr_data = cmd.fill_wr ? y : g1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            shuf_mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= shuf_mem[slot_reg];
        rd_vld_reg  <= vld_reg[slot_reg];
    end

    // Valid bits make the table read as zero until each word is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Next values of the state registers.
    always_comb
    begin
        start_seed_next = cfg_we ? cfg_wdata : start_seed_reg;
        g1_next         = g1_reg;
        g2_next         = g2_reg;
        last_next       = last_reg;
        seeded_next     = seeded_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp_ready;
        rsp_data_next   = rsp_data_reg;

        if (cmd.accept && cmd.reseed)
        begin
            g1_next     = seed_in;
            g2_next     = seed_in;
            seeded_next = 1'b1;
        end
        else if (cmd.accept && !seeded_reg)
        begin
            g1_next     = start_val;
            seeded_next = 1'b1;
        end

        if (cmd.wr_g1)
        begin
            g1_next = y;
        end
        if (cmd.wr_g2)
        begin
            g2_next = y;
        end
        if (cmd.fill_wr && fill_idx == '0)
        begin
            last_next = y;
        end

        if (cmd.finish)
        begin
            last_next      = comb_out;
            rsp_valid_next = 1'b1;
            rsp_data_next  = comb_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seed_reg <= DATA_W'(1);
            g1_reg         <= DATA_W'(1);
            g2_reg         <= SEED2_RESET;
            last_reg       <= '0;
            seeded_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            start_seed_reg <= start_seed_next;
            g1_reg         <= g1_next;
            g2_reg         <= g2_next;
            last_reg       <= last_next;
            seeded_reg     <= seeded_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign sts.out_hold = rsp_valid_reg & ~rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_data     = rsp_data_reg;

endmodule

`default_nettype wire

// File: hdl/lcsr_ctrl.sv
// ----------------------------------------------------------------------------
// lcsr_ctrl: sequencer of the combined LCG shuffle generator
// Steps the shared Schrage unit through the reseed fill and the two
// generator steps of a draw, then triggers the combine and slot refill.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_ctrl
    import lcsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int IW          = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_command,
    output logic          req_ready,
    output lcsr_cmd_t     cmd,
    output logic [IW-1:0] fill_idx,
    input  lcsr_sts_t     sts
);

    localparam int CW = $clog2(TABLE_DEPTH + 8);
    localparam logic [CW-1:0] CNT_START = CW'(TABLE_DEPTH + 7);
    localparam logic [CW-1:0] CNT_FILL  = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FILL   = 5'b00010,
        ST_STEP1  = 5'b00100,
        ST_STEP2  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid & req_ready;
    assign fill_idx  = cnt_reg[IW-1:0];

    // State transitions and per-state commands.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = '0;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.accept   = accept;
        cmd.reseed   = req_command;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = CNT_START;
                    state_next = req_command ? ST_FILL : ST_STEP1;
                end
            end
            ST_FILL:
            begin
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == PH_LAST)
                begin
                    cmd.wr_g1   = 1'b1;
                    cmd.fill_wr = (cnt_reg < CNT_FILL);
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_STEP1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end
            ST_STEP1:
            begin
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == PH_LAST)
                begin
                    cmd.wr_g1  = 1'b1;
                    state_next = ST_STEP2;
                end
            end
            ST_STEP2:
            begin
                cmd.sel_gen2 = 1'b1;
                phase_next   = phase_reg + PH_W'(1);
                if (phase_reg == PH_LAST)
                begin
                    cmd.wr_g2  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_hold)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/combined_lcg_shuffle_rng_unit.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit: combined LCG generator with shuffle table
// Each request either draws one number (command 0) or reseeds from
// seed_value and then draws (command 1). Every request yields exactly one
// result on the rsp channel; random_value / 2147483563 is the fraction.
// Requests are taken on req when valid and ready are high; ready is high
// whenever the sequencer is idle, also while a result still waits in the
// output register. Each Schrage step runs through the shared multiplier
// pipeline; a draw steps generator one, then generator two, then combines
// and registers the result before the next request can be taken.
// A reseed first runs the warm-up steps and the table fill in that unit.
// If the receiver stalls, the finished result stays in the output register
// and the next request is still taken; its result waits in the sequencer
// until the register frees. cfg_we/cfg_wdata write start_seed, the
// generator one state used by the first draw when no reseed came first.
// Reset restores start_seed 1, generator two 123456789, last output 0 and
// a shuffle table that reads as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module combined_lcg_shuffle_rng_unit
    import lcsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    lcsr_req_if.sink          req,
    lcsr_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    lcsr_cmd_t     cmd;
    lcsr_sts_t     sts;
    logic [IW-1:0] fill_idx;
    logic          req_ready;
    logic          rsp_valid;
    logic [DATA_W-1:0] rsp_data;

    // Sequencer.
    lcsr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .fill_idx    (fill_idx),
        .sts         (sts)
    );

    // Generator states, shuffle table and result register.
    lcsr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .seed_value (req.seed_value),
        .cmd        (cmd),
        .fill_idx   (fill_idx),
        .sts        (sts),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp_valid),
        .rsp_data   (rsp_data)
    );

    assign req.ready        = req_ready;
    assign rsp.valid        = rsp_valid;
    assign rsp.random_value = rsp_data;

endmodule

`default_nettype wire
